@@ hdl/lsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared codes and controller/datapath interface types for the LRU cache
// simulator core.
// ----------------------------------------------------------------------------
`default_nettype none

package lsc_pkg;

  localparam int unsigned ADDR_W    = 64;
  localparam int unsigned TAG_W     = 64;
  localparam int unsigned IDX_W     = 7;   // widest set index a 3-bit set_bits can ask for
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // operation codes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_FETCH  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_ACCESS = 4'b0100,
    ST_SECOND = 4'b1000
  } state_e;

  typedef struct packed {
    logic capture;   // latch item, issue set read
    logic clr_step;  // write one cleared row
    logic access;    // first access: update set, counters, result
    logic second;    // second access of a modify: always a hit
  } lsc_cmd_t;

  typedef struct packed {
    logic clr_last;  // clearing the last row
    logic out_free;  // result register can take a new transfer
    logic in_fetch;  // offered item is an instruction fetch
    logic is_modify; // captured item is a modify
  } lsc_status_t;

endpackage

`default_nettype wire

@@ hdl/lsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsc_ctrl
// Sequencer: clearing pass after reset, item capture, first and second access.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire lsc_pkg::lsc_status_t status_i,
  output lsc_pkg::lsc_cmd_t         cmd_o
);

  lsc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lsc_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = lsc_pkg::ST_IDLE;
        end
      end
      lsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          // drop fetches right here
          if (!status_i.in_fetch) begin
            state_d = lsc_pkg::ST_ACCESS;
          end
        end
      end
      lsc_pkg::ST_ACCESS: begin
        if (status_i.out_free) begin
          cmd_o.access = 1'b1;
          state_d = status_i.is_modify ? lsc_pkg::ST_SECOND : lsc_pkg::ST_IDLE;
        end
      end
      lsc_pkg::ST_SECOND: begin
        if (status_i.out_free) begin
          cmd_o.second = 1'b1;
          state_d = lsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lsc_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/lsc_datapath.sv @@
// ----------------------------------------------------------------------------
// lsc_datapath
// Configuration registers, set memory, hit/replace logic, counters and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lsc_datapath #(
  parameter int unsigned MAX_SETS = 64,
  parameter int unsigned MAX_WAYS = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lsc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [lsc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [lsc_pkg::ADDR_W-1:0]       address_i,
  input  wire logic                             out_ready_i,
  input  wire lsc_pkg::lsc_cmd_t                cmd_i,
  output lsc_pkg::lsc_status_t                  status_o,
  output logic                                  out_valid_o,
  output logic [1:0]                            outcome_o,
  output logic [5:0]                            set_index_o,
  output logic [31:0]                           hit_total_o,
  output logic [31:0]                           miss_total_o,
  output logic [31:0]                           eviction_total_o,
  output logic                                  last_o
);

  localparam int unsigned SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned AW = WW;
  localparam int unsigned OW = $clog2(MAX_WAYS + 1);
  localparam int unsigned TW = lsc_pkg::TAG_W;
  localparam int unsigned IW = lsc_pkg::IDX_W;
  localparam int unsigned IDX_DEPTH = 1 << IW;
  localparam logic [AW-1:0] AGE_MAX = AW'(MAX_WAYS - 1);

  // configuration
  logic [2:0] cfg_set_bits_q;
  logic [5:0] cfg_block_bits_q;
  logic [3:0] cfg_ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_set_bits_q   <= 3'd0;
      cfg_block_bits_q <= 6'd0;
      cfg_ways_q       <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lsc_pkg::CFG_SET_BITS:   cfg_set_bits_q   <= cfg_data_i[2:0];
        lsc_pkg::CFG_BLOCK_BITS: cfg_block_bits_q <= cfg_data_i[5:0];
        lsc_pkg::CFG_WAYS:       cfg_ways_q       <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // set index reduction table: raw index modulo MAX_SETS
  logic [SW-1:0] set_tbl [IDX_DEPTH];
  for (genvar g = 0; g < IDX_DEPTH; g++) begin : g_set_tbl
    assign set_tbl[g] = SW'(g % MAX_SETS);
  end

  // address split
  logic [6:0]      split;
  logic [TW-1:0]   tag_d;
  logic [IW-1:0]   idx_mask;
  logic [IW-1:0]   idx_raw;
  logic [lsc_pkg::ADDR_W-1:0] addr_blk;
  logic [SW-1:0]   set_d;

  always_comb begin
    split    = 7'(cfg_set_bits_q) + 7'(cfg_block_bits_q);
    tag_d    = (split >= 7'd64) ? '0 : (address_i >> split[5:0]);
    addr_blk = address_i >> cfg_block_bits_q;
    idx_mask = IW'((8'd1 << cfg_set_bits_q) - 8'd1);
    idx_raw  = addr_blk[IW-1:0] & idx_mask;
    set_d    = set_tbl[idx_raw];
  end

  logic [TW-1:0] tag_q;
  logic [SW-1:0] set_q;
  logic [1:0]    op_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tag_q <= tag_d;
      set_q <= set_d;
      op_q  <= operation_i;
    end
  end

  // set memory: one row per set
  logic [MAX_WAYS-1:0]                valid_mem [MAX_SETS];
  logic [MAX_WAYS-1:0][AW-1:0]        age_mem   [MAX_SETS];
  logic [MAX_WAYS-1:0][TW-1:0]        tag_mem   [MAX_SETS];

  logic [MAX_WAYS-1:0]                rd_valid_q;
  logic [MAX_WAYS-1:0][AW-1:0]        rd_age_q;
  logic [MAX_WAYS-1:0][TW-1:0]        rd_tag_q;

  logic [MAX_WAYS-1:0]                wr_valid;
  logic [MAX_WAYS-1:0][AW-1:0]        wr_age;
  logic [MAX_WAYS-1:0][TW-1:0]        wr_tag;
  logic [MAX_WAYS-1:0]                new_valid;
  logic [MAX_WAYS-1:0][AW-1:0]        new_age;
  logic [MAX_WAYS-1:0][TW-1:0]        new_tag;
  logic [SW-1:0]                      wr_addr;
  logic                               wr_en;

  logic [SW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + SW'(1);
    end
  end

  always_comb begin
    wr_en    = cmd_i.clr_step | cmd_i.access;
    wr_addr  = cmd_i.clr_step ? clr_q : set_q;
    wr_valid = cmd_i.clr_step ? '0 : new_valid;
    wr_age   = cmd_i.clr_step ? '0 : new_age;
    wr_tag   = new_tag;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      valid_mem[wr_addr] <= wr_valid;
      age_mem[wr_addr]   <= wr_age;
      tag_mem[wr_addr]   <= wr_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd_valid_q <= valid_mem[set_d];
      rd_age_q   <= age_mem[set_d];
      rd_tag_q   <= tag_mem[set_d];
    end
  end

  // lookup and replacement
  logic [OW-1:0]       nways;
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic                hit_any;
  logic [WW-1:0]       hit_way;
  logic                free_any;
  logic [WW-1:0]       free_way;
  logic [AW-1:0]       best_age;
  logic [WW-1:0]       victim;
  logic [WW-1:0]       use_way;
  logic [OW-1:0]       old_age;
  lsc_pkg::outcome_e   outcome;

  always_comb begin
    if (cfg_ways_q == 4'd0) begin
      nways = OW'(1);
    end else if (int'(cfg_ways_q) > MAX_WAYS) begin
      nways = OW'(MAX_WAYS);
    end else begin
      nways = OW'(cfg_ways_q);
    end

    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i]  = (i < int'(nways));
      hit_vec[i] = in_use[i] && rd_valid_q[i] && (rd_tag_q[i] == tag_q);
    end

    // lowest matching way wins
    hit_any = 1'b0;
    hit_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_any = 1'b1;
        hit_way = WW'(i);
      end
    end

    // highest invalid way; oldest valid way, lowest index on ties
    free_any = 1'b0;
    free_way = '0;
    best_age = '0;
    victim   = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i]) begin
        if (!rd_valid_q[i]) begin
          free_any = 1'b1;
          free_way = WW'(i);
        end else if ((i == 0) || (rd_age_q[i] > best_age)) begin
          best_age = rd_age_q[i];
          victim   = WW'(i);
        end
      end
    end

    new_valid = rd_valid_q;
    new_tag   = rd_tag_q;
    priority if (hit_any) begin
      outcome = lsc_pkg::OUT_HIT;
      use_way = hit_way;
      old_age = OW'(rd_age_q[hit_way]);
    end else if (free_any) begin
      outcome = lsc_pkg::OUT_FILL;
      use_way = free_way;
      old_age = nways;
      new_valid[free_way] = 1'b1;
      new_tag[free_way]   = tag_q;
    end else begin
      outcome = lsc_pkg::OUT_EVICT;
      use_way = victim;
      old_age = OW'(rd_age_q[victim]);
      new_tag[victim] = tag_q;
    end

    // promote the used way, age the younger valid ones
    new_age = rd_age_q;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i]) begin
        if (i == int'(use_way)) begin
          new_age[i] = '0;
        end else if (rd_valid_q[i] && (int'(rd_age_q[i]) < int'(old_age)) &&
                     (rd_age_q[i] != AGE_MAX)) begin
          new_age[i] = rd_age_q[i] + AW'(1);
        end
      end
    end
  end

  // running totals
  logic [31:0] hits_q, misses_q, evictions_q;
  logic [31:0] hits_d, misses_d, evictions_d;

  always_comb begin
    hits_d      = hits_q;
    misses_d    = misses_q;
    evictions_d = evictions_q;
    if (cmd_i.access) begin
      if (outcome == lsc_pkg::OUT_HIT) begin
        hits_d = hits_q + 32'd1;
      end else begin
        misses_d = misses_q + 32'd1;
      end
      if (outcome == lsc_pkg::OUT_EVICT) begin
        evictions_d = evictions_q + 32'd1;
      end
    end else if (cmd_i.second) begin
      hits_d = hits_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      misses_q    <= '0;
      evictions_q <= '0;
    end else begin
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      evictions_q <= evictions_d;
    end
  end

  // result register
  logic            out_valid_q;
  logic            out_load;
  logic [SW+5:0]   set_ext;

  assign out_load = cmd_i.access | cmd_i.second;
  assign set_ext  = {6'd0, set_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      outcome_o        <= cmd_i.second ? lsc_pkg::OUT_HIT : outcome;
      set_index_o      <= set_ext[5:0];
      hit_total_o      <= hits_d;
      miss_total_o     <= misses_d;
      eviction_total_o <= evictions_d;
      last_o           <= cmd_i.second | (op_q != lsc_pkg::OP_MODIFY);
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o.clr_last  = (clr_q == SW'(MAX_SETS - 1));
    status_o.out_free  = !out_valid_q || out_ready_i;
    status_o.in_fetch  = (operation_i == lsc_pkg::OP_FETCH);
    status_o.is_modify = (op_q == lsc_pkg::OP_MODIFY);
  end

endmodule

`default_nettype wire

@@ hdl/lru_set_assoc_cache_sim_core.sv @@
// An accepted load or store reads its set, then writes it back and loads its
// result into the output register once that register is free; a modify then
// loads its second (hit) result the same way, and a fetch is dropped at once.
// A new item is accepted only after the previous one's results are loaded.
// Reset: a clearing pass, a row at a time, zeroes valid and age of every set;
// no item is accepted meanwhile, configuration writes are taken as ever.
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_sim_core
// Tag-only set-associative cache with true LRU replacement: reports hit,
// fill or eviction per access and running totals of each.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_set_assoc_cache_sim_core #(
  parameter int unsigned MAX_SETS = 64,
  parameter int unsigned MAX_WAYS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [lsc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lsc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     operation_i,
  input  wire logic [lsc_pkg::ADDR_W-1:0]     address_i,
  // result items
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [1:0]                          outcome_o,
  output logic [5:0]                          set_index_o,
  output logic [31:0]                         hit_total_o,
  output logic [31:0]                         miss_total_o,
  output logic [31:0]                         eviction_total_o,
  output logic                                last_o
);

  // Controller and datapath talk only through these two groups.
  lsc_pkg::lsc_cmd_t    cmd;
  lsc_pkg::lsc_status_t status;

  // Sequencer: clear after reset, then per item capture the address and
  // read the set, write back the updated set and hand over the result, and
  // for a modify add the second (always hit) result. Each result is held in
  // the output register until its transfer; a new item is accepted while a
  // result still waits.
  lsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: configuration, address split, set memory with one row per set
  // (valid, LRU age and tag of every way), hit/fill/evict selection, totals.
  lsc_datapath #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (operation_i),
    .address_i        (address_i),
    .out_ready_i      (out_ready_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .outcome_o        (outcome_o),
    .set_index_o      (set_index_o),
    .hit_total_o      (hit_total_o),
    .miss_total_o     (miss_total_o),
    .eviction_total_o (eviction_total_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire
